// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file lfps_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lfps_pkg.sv =====
// Types and constants of the lane-following PID steering unit.
`default_nettype none

package lfps_pkg;

   // Widths
   localparam int X_BITS        = 11;
   localparam int MAX_ROWS      = 256;
   localparam int ROW_BITS      = $clog2(MAX_ROWS + 1);
   localparam int LOOK_BITS     = 8;
   localparam int GAIN_BITS     = 24;
   localparam int SPAN_BITS     = 11;
   localparam int SPEED_BITS    = 8;
   localparam int ERR_BITS      = 21;
   localparam int DIFF_BITS     = ERR_BITS + 1;
   localparam int SUM_BITS      = 48;
   localparam int STEER_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   // Register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_LOOK_ROW     = 3'd3,
      CSR_TURN_MODE    = 3'd4,
      CSR_CAR_COLUMN   = 3'd5,
      CSR_LANE_SPAN    = 3'd6,
      CSR_CRUISE_SPEED = 3'd7
   } csr_index_type;

   // Tracking modes; the unused code behaves as straight
   typedef enum logic [1:0] {
      MODE_STRAIGHT = 2'd0,
      MODE_RIGHT    = 2'd1,
      MODE_LEFT     = 2'd2
   } turn_mode_type;

   // Register reset values
   localparam logic signed [GAIN_BITS-1:0] GAIN_P_RESET = 24'sd891290;
   localparam logic signed [GAIN_BITS-1:0] GAIN_I_RESET = 24'sd839;
   localparam logic signed [GAIN_BITS-1:0] GAIN_D_RESET = 24'sd94372;

   // Lane offset in 1/256 px: span*128 straight, round(span*76.8) right,
   // round(span*179.2) left; the rounded ones are (span*k + 5) / 10
   localparam int SCALE_NUM_BITS  = SPAN_BITS + 11;
   localparam int SCALE_RIGHT     = 768;
   localparam int SCALE_LEFT      = 1792;
   localparam int SCALE_ROUND     = 5;
   localparam int STRAIGHT_SHIFT  = 7;
   localparam int RECIP_BITS      = 24;
   localparam int RECIP_SHIFT     = 27;
   localparam logic [RECIP_BITS-1:0] RECIP_DIV10 = 24'd13421773;
   localparam int SCALE_PROD_BITS = SCALE_NUM_BITS + RECIP_BITS;
   localparam int OFF_BITS        = 19;

   // Integral limits
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // Power drops to 1 at an error of 65 px
   localparam logic signed [ERR_BITS-1:0] PWR_ERR_LIM = 21'sd16640;

   // Steer sum and clamp, Q28 degrees
   localparam int PTERM_BITS  = GAIN_BITS + ERR_BITS;
   localparam int DTERM_BITS  = GAIN_BITS + DIFF_BITS;
   localparam int IHI_BITS    = GAIN_BITS + SUM_BITS / 2;
   localparam int ILO_BITS    = GAIN_BITS + SUM_BITS / 2 + 1;
   localparam int PD_BITS     = DTERM_BITS + 1;
   localparam int TOTAL_BITS  = GAIN_BITS + SUM_BITS;
   localparam int CLAMP_BITS  = 37;
   localparam logic signed [CLAMP_BITS-1:0] STEER_LIM = 37'sh4_1000_0000;
   localparam int Q_DROP      = 20;
   localparam logic signed [CLAMP_BITS:0] ROUND_HALF = 38'sd524288;

   // Output steer limit, degrees with 8 fraction bits
   localparam logic signed [STEER_BITS-1:0] STEER_OUT_LIM = 16'sd16640;

endpackage

`default_nettype wire

// ===== hdl/lane_follow_pid_steering_unit.sv =====
// Lane-following PID steering unit: row tracking and the per-frame PID pipeline.
//
// Usage:
//  - req channel: one lane row per word (left/right x with present flags),
//    rows of a frame in order starting at row 0, req_last_row on the final one.
//    A row can be taken in every cycle while req_stall is low; frames may follow back to back.
//  - rsp channel: one word per frame (steer command, drive power, lost flag),
//    issued only for the last row. Rows before it produce nothing.
//  - csr port: write-only registers, written when the unit holds no frame.
//  - Pipeline: the result of a frame passes, after its last row is taken,
//    through tracking, error, integral update, products, partial sums, clamp and
//    the output register. Throughput is one row per cycle and one frame result
//    per cycle while rsp_stall holds nothing, so consecutive frames never wait
//    on each other.
//  - Stall: when rsp_stall holds a result, the stages behind it keep filling
//    until the pipeline is full; only then req_stall rises.
//  - Reset (synchronous): registers return to their defaults, the frame
//    tracker, error history and integral clear, and the pipeline empties.
`default_nettype none

module lane_follow_pid_steering_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [lfps_pkg::X_BITS-1:0]           req_left_x,
   input  wire logic                                  req_left_ok,
   input  wire logic [lfps_pkg::X_BITS-1:0]           req_right_x,
   input  wire logic                                  req_right_ok,
   input  wire logic                                  req_last_row,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic signed [lfps_pkg::STEER_BITS-1:0] rsp_steer_cmd,
   output      logic [lfps_pkg::SPEED_BITS-1:0]       rsp_drive_power,
   output      logic                                  rsp_lane_lost,
   input  wire logic                                  csr_write,
   input  wire logic [lfps_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // ---------------- configuration registers ----------------
   logic signed [lfps_pkg::GAIN_BITS-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [lfps_pkg::LOOK_BITS-1:0]        look_row_ff;
   lfps_pkg::turn_mode_type               turn_mode_ff;
   logic [lfps_pkg::X_BITS-1:0]           car_column_ff;
   logic [lfps_pkg::SPAN_BITS-1:0]        lane_span_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]       cruise_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= lfps_pkg::GAIN_P_RESET;
         gain_i_ff       <= lfps_pkg::GAIN_I_RESET;
         gain_d_ff       <= lfps_pkg::GAIN_D_RESET;
         look_row_ff     <= '0;
         turn_mode_ff    <= lfps_pkg::MODE_STRAIGHT;
         car_column_ff   <= '0;
         lane_span_ff    <= '0;
         cruise_speed_ff <= '0;
      end else if (csr_write) begin
         unique case (lfps_pkg::csr_index_type'(csr_index))
            lfps_pkg::CSR_GAIN_P:       gain_p_ff       <= $signed(csr_data);
            lfps_pkg::CSR_GAIN_I:       gain_i_ff       <= $signed(csr_data);
            lfps_pkg::CSR_GAIN_D:       gain_d_ff       <= $signed(csr_data);
            lfps_pkg::CSR_LOOK_ROW:     look_row_ff     <= csr_data[lfps_pkg::LOOK_BITS-1:0];
            lfps_pkg::CSR_TURN_MODE:    turn_mode_ff    <= lfps_pkg::turn_mode_type'(csr_data[1:0]);
            lfps_pkg::CSR_CAR_COLUMN:   car_column_ff   <= csr_data[lfps_pkg::X_BITS-1:0];
            lfps_pkg::CSR_LANE_SPAN:    lane_span_ff    <= csr_data[lfps_pkg::SPAN_BITS-1:0];
            lfps_pkg::CSR_CRUISE_SPEED: cruise_speed_ff <= csr_data[lfps_pkg::SPEED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   logic rsp_valid_ff;
   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;

   // a stage loads when it is empty or the one after it moves
   assign en_g = !rsp_valid_ff || !rsp_stall;
   assign en_f = !f_valid_ff || en_g;
   assign en_e = !e_valid_ff || en_f;
   assign en_d = !d_valid_ff || en_e;
   assign en_c = !c_valid_ff || en_d;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;

   assign req_stall = !en_a;

   logic row_fire;
   assign row_fire = req_valid && !req_stall;

   // ---------------- row tracking ----------------
   logic [lfps_pkg::ROW_BITS-1:0] row_index_ff;
   logic [lfps_pkg::X_BITS-1:0]   found_x_ff;
   logic                          found_flag_ff;
   logic [lfps_pkg::X_BITS-1:0]   row_x;
   logic                          row_ok;
   logic                          row_hit;

   always_comb begin
      if (turn_mode_ff == lfps_pkg::MODE_LEFT) begin
         row_x  = req_left_x;
         row_ok = req_left_ok;
      end else begin
         row_x  = req_right_x;
         row_ok = req_right_ok;
      end
      row_hit = row_ok
             && (row_index_ff != '0)
             && (row_index_ff <= lfps_pkg::ROW_BITS'(look_row_ff))
             && (row_index_ff < lfps_pkg::ROW_BITS'(lfps_pkg::MAX_ROWS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff  <= '0;
         found_x_ff    <= '0;
         found_flag_ff <= 1'b0;
      end else if (row_fire) begin
         if (req_last_row) begin
            // clear for the next frame
            row_index_ff  <= '0;
            found_x_ff    <= '0;
            found_flag_ff <= 1'b0;
         end else begin
            if (row_index_ff < lfps_pkg::ROW_BITS'(lfps_pkg::MAX_ROWS)) begin
               row_index_ff <= row_index_ff + 1'b1;
            end
            if (row_hit) begin
               found_x_ff    <= row_x;
               found_flag_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------- stage A: frame word ----------------
   logic [lfps_pkg::X_BITS-1:0] a_x_ff;
   logic                        a_found_ff;
   lfps_pkg::turn_mode_type     a_mode_ff;

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_x_ff     <= row_hit ? row_x : found_x_ff;
         a_found_ff <= row_hit || found_flag_ff;
         a_mode_ff  <= turn_mode_ff;
      end
   end

   // ---------------- stage B: error of the frame ----------------
   logic [lfps_pkg::SCALE_NUM_BITS-1:0]      scale_num;
   logic [lfps_pkg::SCALE_PROD_BITS-1:0]     scale_prod;
   logic [lfps_pkg::OFF_BITS-1:0]            span_off;
   logic signed [lfps_pkg::X_BITS:0]         dx;
   logic signed [lfps_pkg::X_BITS+8:0]       dpix;
   logic signed [lfps_pkg::ERR_BITS-1:0]     err_frame;
   logic signed [lfps_pkg::ERR_BITS-1:0]     b_err_ff;
   logic                                     b_lost_ff;

   always_comb begin
      if (a_mode_ff == lfps_pkg::MODE_LEFT) begin
         scale_num = {{(lfps_pkg::SCALE_NUM_BITS-lfps_pkg::SPAN_BITS){1'b0}}, lane_span_ff}
                   * lfps_pkg::SCALE_NUM_BITS'(lfps_pkg::SCALE_LEFT)
                   + lfps_pkg::SCALE_NUM_BITS'(lfps_pkg::SCALE_ROUND);
      end else begin
         scale_num = {{(lfps_pkg::SCALE_NUM_BITS-lfps_pkg::SPAN_BITS){1'b0}}, lane_span_ff}
                   * lfps_pkg::SCALE_NUM_BITS'(lfps_pkg::SCALE_RIGHT)
                   + lfps_pkg::SCALE_NUM_BITS'(lfps_pkg::SCALE_ROUND);
      end
      // divide by ten through the reciprocal
      scale_prod = {{lfps_pkg::RECIP_BITS{1'b0}}, scale_num}
                 * {{lfps_pkg::SCALE_NUM_BITS{1'b0}}, lfps_pkg::RECIP_DIV10};
      dx   = $signed({1'b0, a_x_ff}) - $signed({1'b0, car_column_ff});
      dpix = {dx, 8'h00};
      case (a_mode_ff)
         lfps_pkg::MODE_RIGHT: begin
            span_off  = scale_prod[lfps_pkg::RECIP_SHIFT +: lfps_pkg::OFF_BITS];
            err_frame = lfps_pkg::ERR_BITS'(dpix) - $signed({2'b00, span_off});
         end
         lfps_pkg::MODE_LEFT: begin
            span_off  = scale_prod[lfps_pkg::RECIP_SHIFT +: lfps_pkg::OFF_BITS];
            err_frame = lfps_pkg::ERR_BITS'(dpix) + $signed({2'b00, span_off});
         end
         default: begin
            span_off  = {1'b0, lane_span_ff, {lfps_pkg::STRAIGHT_SHIFT{1'b0}}};
            err_frame = lfps_pkg::ERR_BITS'(dpix) - $signed({2'b00, span_off});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_err_ff  <= err_frame;
         b_lost_ff <= !a_found_ff;
      end
   end

   // ---------------- stage C: error history and integral ----------------
   logic signed [lfps_pkg::ERR_BITS-1:0]   error_now_ff, error_before_ff;
   logic signed [lfps_pkg::SUM_BITS-1:0]   error_sum_ff;
   logic signed [lfps_pkg::ERR_BITS-1:0]   err_in;
   logic signed [lfps_pkg::SUM_BITS:0]     sum_wide;
   logic signed [lfps_pkg::SUM_BITS-1:0]   sum_in;
   logic signed [lfps_pkg::DIFF_BITS-1:0]  diff_in;
   logic [lfps_pkg::SPEED_BITS-1:0]        power_in;
   logic signed [lfps_pkg::ERR_BITS-1:0]   c_err_ff;
   logic signed [lfps_pkg::SUM_BITS-1:0]   c_sum_ff;
   logic signed [lfps_pkg::DIFF_BITS-1:0]  c_diff_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]        c_power_ff;
   logic                                   c_lost_ff;

   always_comb begin
      // a lost lane keeps the last error
      err_in   = b_lost_ff ? error_now_ff : b_err_ff;
      sum_wide = (lfps_pkg::SUM_BITS+1)'(error_sum_ff) + (lfps_pkg::SUM_BITS+1)'(err_in);
      if (sum_wide[lfps_pkg::SUM_BITS] != sum_wide[lfps_pkg::SUM_BITS-1]) begin
         sum_in = sum_wide[lfps_pkg::SUM_BITS] ? lfps_pkg::SUM_MIN : lfps_pkg::SUM_MAX;
      end else begin
         sum_in = sum_wide[lfps_pkg::SUM_BITS-1:0];
      end
      diff_in  = lfps_pkg::DIFF_BITS'(err_in) - lfps_pkg::DIFF_BITS'(error_before_ff);
      power_in = (err_in >= lfps_pkg::PWR_ERR_LIM) ? lfps_pkg::SPEED_BITS'(1) : cruise_speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_now_ff    <= '0;
         error_before_ff <= '0;
         error_sum_ff    <= '0;
      end else if (en_c && b_valid_ff) begin
         error_now_ff    <= err_in;
         error_before_ff <= err_in;
         error_sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_err_ff   <= err_in;
         c_sum_ff   <= sum_in;
         c_diff_ff  <= diff_in;
         c_power_ff <= power_in;
         c_lost_ff  <= b_lost_ff;
      end
   end

   // ---------------- stage D: gain products ----------------
   logic signed [lfps_pkg::PTERM_BITS-1:0] d_pterm_ff;
   logic signed [lfps_pkg::DTERM_BITS-1:0] d_dterm_ff;
   logic signed [lfps_pkg::IHI_BITS-1:0]   d_ihi_ff;
   logic signed [lfps_pkg::ILO_BITS-1:0]   d_ilo_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]        d_power_ff;
   logic                                   d_lost_ff;

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_pterm_ff <= gain_p_ff * c_err_ff;
         d_dterm_ff <= gain_d_ff * c_diff_ff;
         // integral term in two halves of the sum
         d_ihi_ff   <= gain_i_ff * $signed(c_sum_ff[lfps_pkg::SUM_BITS-1:lfps_pkg::SUM_BITS/2]);
         d_ilo_ff   <= gain_i_ff * $signed({1'b0, c_sum_ff[lfps_pkg::SUM_BITS/2-1:0]});
         d_power_ff <= c_power_ff;
         d_lost_ff  <= c_lost_ff;
      end
   end

   // ---------------- stage E: partial sums ----------------
   logic signed [lfps_pkg::TOTAL_BITS-1:0] e_isum_ff;
   logic signed [lfps_pkg::PD_BITS-1:0]    e_pdsum_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]        e_power_ff;
   logic                                   e_lost_ff;

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_isum_ff  <= (lfps_pkg::TOTAL_BITS'(d_ihi_ff) <<< (lfps_pkg::SUM_BITS/2))
                     + lfps_pkg::TOTAL_BITS'(d_ilo_ff);
         e_pdsum_ff <= lfps_pkg::PD_BITS'(d_pterm_ff) + lfps_pkg::PD_BITS'(d_dterm_ff);
         e_power_ff <= d_power_ff;
         e_lost_ff  <= d_lost_ff;
      end
   end

   // ---------------- stage F: total and clamp ----------------
   logic signed [lfps_pkg::TOTAL_BITS-1:0] steer_total;
   logic signed [lfps_pkg::CLAMP_BITS-1:0] steer_clamp;
   logic signed [lfps_pkg::CLAMP_BITS-1:0] f_clamp_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]        f_power_ff;
   logic                                   f_lost_ff;

   always_comb begin
      steer_total = e_isum_ff + lfps_pkg::TOTAL_BITS'(e_pdsum_ff);
      if (steer_total > lfps_pkg::TOTAL_BITS'(lfps_pkg::STEER_LIM)) begin
         steer_clamp = lfps_pkg::STEER_LIM;
      end else if (steer_total < -lfps_pkg::TOTAL_BITS'(lfps_pkg::STEER_LIM)) begin
         steer_clamp = -lfps_pkg::STEER_LIM;
      end else begin
         steer_clamp = steer_total[lfps_pkg::CLAMP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         f_clamp_ff <= steer_clamp;
         f_power_ff <= e_power_ff;
         f_lost_ff  <= e_lost_ff;
      end
   end

   // ---------------- stage G: round, negate, output word ----------------
   logic signed [lfps_pkg::CLAMP_BITS:0]   steer_round;
   logic signed [lfps_pkg::STEER_BITS-1:0] steer_q8;
   logic signed [lfps_pkg::STEER_BITS-1:0] steer_cmd_in;
   logic signed [lfps_pkg::STEER_BITS-1:0] steer_cmd_ff;
   logic [lfps_pkg::SPEED_BITS-1:0]        drive_power_ff;
   logic                                   lane_lost_ff;

   always_comb begin
      steer_round  = (lfps_pkg::CLAMP_BITS+1)'(f_clamp_ff) + lfps_pkg::ROUND_HALF;
      steer_q8     = steer_round[lfps_pkg::Q_DROP +: lfps_pkg::STEER_BITS];
      steer_cmd_in = f_lost_ff ? '0 : -steer_q8;
   end

   always_ff @(posedge clock) begin
      if (en_g) begin
         steer_cmd_ff   <= steer_cmd_in;
         drive_power_ff <= f_power_ff;
         lane_lost_ff   <= f_lost_ff;
      end
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff   <= row_fire && req_last_row;
         if (en_b) b_valid_ff   <= a_valid_ff;
         if (en_c) c_valid_ff   <= b_valid_ff;
         if (en_d) d_valid_ff   <= c_valid_ff;
         if (en_e) e_valid_ff   <= d_valid_ff;
         if (en_f) f_valid_ff   <= e_valid_ff;
         if (en_g) rsp_valid_ff <= f_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_steer_cmd   = steer_cmd_ff;
   assign rsp_drive_power = drive_power_ff;
   assign rsp_lane_lost   = lane_lost_ff;

endmodule

`default_nettype wire

// ===== hdl/lfps_checker.sv =====
// Port-level checks of the lane-following PID steering unit, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module lfps_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic signed [lfps_pkg::STEER_BITS-1:0] rsp_steer_cmd,
   input wire logic [lfps_pkg::SPEED_BITS-1:0]       rsp_drive_power,
   input wire logic                                  rsp_lane_lost
);

   // a held word keeps its contents
   `ASSERT_CLK(rsp_hold_a, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_steer_cmd) && $stable(rsp_drive_power) && $stable(rsp_lane_lost), "rsp word changed while stalled")

   // a lost lane gives no steering
   `ASSERT_CLK(lost_zero_a, clock, reset, rsp_valid && rsp_lane_lost |-> rsp_steer_cmd == '0, "steer not zero on lost lane")

   // steer stays inside +/-65 degrees
   `ASSERT_CLK(steer_range_a, clock, reset, rsp_valid |-> (rsp_steer_cmd <= lfps_pkg::STEER_OUT_LIM) && (rsp_steer_cmd >= -lfps_pkg::STEER_OUT_LIM), "steer outside limit")

   // no result straight out of reset
   `ASSERT_CLK_ALWAYS(reset_empty_a, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind lane_follow_pid_steering_unit lfps_checker u_lfps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_steer_cmd   (rsp_steer_cmd),
   .rsp_drive_power (rsp_drive_power),
   .rsp_lane_lost   (rsp_lane_lost)
);

`default_nettype wire

// ===== sim/tb_lane_follow_pid_steering_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the lane-following PID steering unit: lane rows in, frame words out.
module tb_lane_follow_pid_steering_unit;

   localparam int HOLD_CYCLES  = 300;
   localparam int STUCK_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 12;
   localparam int ROW_TARGET   = 600;
   localparam int X_TOP        = (1 << lfps_pkg::X_BITS) - 1;

   typedef struct packed {
      logic [lfps_pkg::X_BITS-1:0] left_x;
      logic                        left_ok;
      logic [lfps_pkg::X_BITS-1:0] right_x;
      logic                        right_ok;
      logic                        last_row;
   } lane_row_type;

   typedef struct packed {
      logic signed [lfps_pkg::STEER_BITS-1:0] steer_cmd;
      logic [lfps_pkg::SPEED_BITS-1:0]        drive_power;
      logic                                   lane_lost;
   } steer_word_type;

   // Tracks the frame, runs the PID math and keeps the frame words still owed.
   class steer_predictor_type;
      localparam logic signed [95:0] TERM_CAP  = 96'sd1 <<< 60;
      localparam logic signed [95:0] STEER_CAP = 96'sd65 <<< 28;
      localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
      localparam longint ACC_LO = -ACC_HI - 1;

      logic signed [lfps_pkg::GAIN_BITS-1:0] kp, ki, kd;
      logic [7:0]                  look_limit;
      logic [1:0]                  mode;
      logic [10:0]                 car_x, span;
      logic [7:0]                  cruise;
      int                          row_at;
      logic [lfps_pkg::X_BITS-1:0] point_x;
      bit                          have_point;
      int                          err_now, err_prev;
      longint                      err_acc;
      steer_word_type              frame_words[$];
      int                          faults;

      function new();
         kp = lfps_pkg::GAIN_P_RESET;
         ki = lfps_pkg::GAIN_I_RESET;
         kd = lfps_pkg::GAIN_D_RESET;
         look_limit = 0;
         mode = 0;
         car_x = 0;
         span = 0;
         cruise = 0;
         row_at = 0;
         point_x = 0;
         have_point = 0;
         err_now = 0;
         err_prev = 0;
         err_acc = 0;
         faults = 0;
      endfunction

      function void set_reg(lfps_pkg::csr_index_type idx,
                            logic [lfps_pkg::CSR_DATA_BITS-1:0] v);
         case (idx)
            lfps_pkg::CSR_GAIN_P:       kp = v;
            lfps_pkg::CSR_GAIN_I:       ki = v;
            lfps_pkg::CSR_GAIN_D:       kd = v;
            lfps_pkg::CSR_LOOK_ROW:     look_limit = v[7:0];
            lfps_pkg::CSR_TURN_MODE:    mode = v[1:0];
            lfps_pkg::CSR_CAR_COLUMN:   car_x = v[10:0];
            lfps_pkg::CSR_LANE_SPAN:    span = v[10:0];
            lfps_pkg::CSR_CRUISE_SPEED: cruise = v[7:0];
         endcase
      endfunction

      function logic signed [95:0] clip(logic signed [95:0] v, logic signed [95:0] cap);
         if (v > cap) return cap;
         if (v < -cap) return -cap;
         return v;
      endfunction

      function void take_row(lane_row_type r);
         logic [lfps_pkg::X_BITS-1:0] x;
         bit ok;
         longint acc;
         int d;
         logic signed [95:0] pe, ps, pd, total, rounded;
         steer_word_type w;
         x  = (mode == lfps_pkg::MODE_LEFT) ? r.left_x : r.right_x;
         ok = (mode == lfps_pkg::MODE_LEFT) ? r.left_ok : r.right_ok;
         if (row_at >= 1 && row_at <= int'(look_limit) && row_at < lfps_pkg::MAX_ROWS && ok)
         begin
            point_x = x;
            have_point = 1;
         end
         if (row_at < lfps_pkg::MAX_ROWS) row_at++;
         if (!r.last_row) return;

         // error in 1/256 px; offsets are span*0.3, 0.5, 0.7 rounded half up
         if (have_point) begin
            err_now = (int'(point_x) - int'(car_x)) * 256;
            if (mode == lfps_pkg::MODE_RIGHT) err_now -= (int'(span) * 768 + 5) / 10;
            else if (mode == lfps_pkg::MODE_LEFT) err_now += (int'(span) * 1792 + 5) / 10;
            else err_now -= int'(span) * 128;
         end
         acc = err_acc + err_now;
         if (acc > ACC_HI) acc = ACC_HI;
         if (acc < ACC_LO) acc = ACC_LO;
         err_acc = acc;
         d = err_now - err_prev;
         err_prev = err_now;

         w.lane_lost = !have_point;
         if (have_point) begin
            pe = kp * err_now;
            ps = ki * err_acc;
            pd = kd * d;
            total = clip(pe, TERM_CAP) + clip(ps, TERM_CAP) + clip(pd, TERM_CAP);
            total = clip(total, STEER_CAP);
            // Q28 to Q8, half up, then negate
            rounded = (total + STEER_CAP + 96'sd524288) >>> 20;
            w.steer_cmd = 16'(96'sd16640 - rounded);
         end else begin
            w.steer_cmd = '0;
         end
         w.drive_power = (err_now >= 16640) ? 8'd1 : cruise;
         frame_words.push_back(w);
         row_at = 0;
         point_x = 0;
         have_point = 0;
      endfunction

      function void check_word(steer_word_type got);
         steer_word_type want;
         if (frame_words.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected word: steer %0d power %0d lost %0b",
                        got.steer_cmd, got.drive_power, got.lane_lost);
            return;
         end
         want = frame_words.pop_front();
         if (got !== want) begin
            faults++;
            if (faults <= 10)
               $display({"word mismatch: steer exp %0d got %0d, power exp %0d got %0d, ",
                         "lost exp %0b got %0b"},
                        want.steer_cmd, got.steer_cmd, want.drive_power, got.drive_power,
                        want.lane_lost, got.lane_lost);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [lfps_pkg::X_BITS-1:0] req_left_x = '0;
   logic req_left_ok = 1'b0;
   logic [lfps_pkg::X_BITS-1:0] req_right_x = '0;
   logic req_right_ok = 1'b0;
   logic req_last_row = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_write = 1'b0;
   lfps_pkg::csr_index_type csr_index = lfps_pkg::CSR_GAIN_P;
   logic [lfps_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   logic req_stall;
   logic rsp_valid;
   logic signed [lfps_pkg::STEER_BITS-1:0] rsp_steer_cmd;
   logic [lfps_pkg::SPEED_BITS-1:0] rsp_drive_power;
   logic rsp_lane_lost;

   steer_predictor_type steer_pred = new();
   int send_idle_pct = 28;
   int recv_idle_pct = 28;
   bit hold_ask = 1'b0;
   int rows_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lane_follow_pid_steering_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_x      (req_left_x),
      .req_left_ok     (req_left_ok),
      .req_right_x     (req_right_x),
      .req_right_ok    (req_right_ok),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steer_cmd   (rsp_steer_cmd),
      .rsp_drive_power (rsp_drive_power),
      .rsp_lane_lost   (rsp_lane_lost),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   function automatic lane_row_type mk_row(int lx, int lo, int rx, int ro, int last);
      lane_row_type r;
      r.left_x = lfps_pkg::X_BITS'(lx);
      r.left_ok = lo[0];
      r.right_x = lfps_pkg::X_BITS'(rx);
      r.right_ok = ro[0];
      r.last_row = last[0];
      return r;
   endfunction

   function automatic int pick_x();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return X_TOP;
         default: return int'($urandom_range(0, X_TOP));
      endcase
   endfunction

   function automatic lane_row_type random_row(int ok_pct, int last);
      return mk_row(pick_x(), int'($urandom_range(0, 99) < ok_pct),
                    pick_x(), int'($urandom_range(0, 99) < ok_pct), last);
   endfunction

   // bound: 1 forces the top value, 2 the bottom one
   function automatic logic [lfps_pkg::CSR_DATA_BITS-1:0] pick_gain(int bound);
      logic [lfps_pkg::CSR_DATA_BITS-1:0] g;
      if (bound == 1) return 24'h7F_FFFF;
      if (bound == 2) return 24'h80_0000;
      case ($urandom_range(0, 7))
         0: g = 24'h7F_FFFF;
         1: g = 24'h80_0000;
         2: g = '0;
         default: begin
            g = 24'($urandom() >> $urandom_range(8, 30));
            if ($urandom_range(0, 1)) g = -g;
         end
      endcase
      return g;
   endfunction

   function automatic int pick_field(int bound, int w);
      if (bound == 1) return (1 << w) - 1;
      if (bound == 2) return 0;
      case ($urandom_range(0, 7))
         0: return 0;
         1: return (1 << w) - 1;
         default: return $urandom_range(0, (1 << w) - 1);
      endcase
   endfunction

   function automatic int pick_look(int bound);
      if (bound == 1) return 255;
      if (bound == 2) return 0;
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 255;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // fill the unused upper data bits with noise
   function automatic logic [lfps_pkg::CSR_DATA_BITS-1:0] junk_above(int v, int w);
      logic [31:0] j;
      j = $urandom();
      return lfps_pkg::CSR_DATA_BITS'((j << w) | v);
   endfunction

   task automatic send_row(lane_row_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_left_x, req_left_ok, req_right_x, req_right_ok, req_last_row} <= r;
      do @(posedge clock); while (req_stall);
      steer_pred.take_row(r);
      rows_sent++;
   endtask

   task automatic send_frame(int rows, int ok_pct);
      for (int k = 0; k < rows; k++) send_row(random_row(ok_pct, int'(k == rows - 1)));
   endtask

   task automatic write_reg(lfps_pkg::csr_index_type idx,
                            logic [lfps_pkg::CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      steer_pred.set_reg(idx, data);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (steer_pred.frame_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_setup(int phase);
      int bound;
      bound = (phase < 2) ? phase + 1 : 0;
      write_reg(lfps_pkg::CSR_GAIN_P, pick_gain(bound));
      write_reg(lfps_pkg::CSR_GAIN_I, pick_gain(bound));
      write_reg(lfps_pkg::CSR_GAIN_D, pick_gain(bound));
      write_reg(lfps_pkg::CSR_LOOK_ROW, junk_above(pick_look(bound), 8));
      write_reg(lfps_pkg::CSR_TURN_MODE, junk_above(phase % 4, 2));
      write_reg(lfps_pkg::CSR_CAR_COLUMN, junk_above(pick_field(bound, 11), 11));
      write_reg(lfps_pkg::CSR_LANE_SPAN, junk_above(pick_field(bound, 11), 11));
      write_reg(lfps_pkg::CSR_CRUISE_SPEED, junk_above(pick_field(bound, 8), 8));
      csr_write <= 1'b0;
   endtask

   initial begin : rsp_side
      int hold_left;
      steer_word_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.steer_cmd = rsp_steer_cmd;
            got.drive_power = rsp_drive_power;
            got.lane_lost = rsp_lane_lost;
            steer_pred.check_word(got);
         end
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck = 0;
         else
            stuck++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int frames;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: look_row is 0, so every frame is lost
      send_row(mk_row(X_TOP, 1, X_TOP, 1, 1));
      send_row(mk_row(0, 1, 0, 1, 0));
      send_row(mk_row(5, 1, 9, 1, 0));
      send_row(mk_row(7, 1, 8, 1, 1));
      drain_pipe();

      // reset gains, search rows 1..4
      write_reg(lfps_pkg::CSR_LOOK_ROW, lfps_pkg::CSR_DATA_BITS'(4));
      csr_write <= 1'b0;
      // a point on row zero alone is ignored
      send_row(mk_row(X_TOP, 1, X_TOP, 1, 0));
      send_row(mk_row(3, 0, 3, 0, 1));
      // highest row in the window wins; row 5 lies past it
      send_row(mk_row(0, 0, 100, 1, 0));
      send_row(mk_row(0, 0, X_TOP, 1, 0));
      send_row(mk_row(X_TOP, 1, 0, 1, 0));
      send_row(mk_row(0, 0, 600, 0, 0));
      send_row(mk_row(0, 0, 33, 1, 0));
      send_row(mk_row(0, 0, 1500, 1, 1));
      // far right edge: large error, power drops to 1
      send_row(mk_row(0, 0, 0, 0, 0));
      send_row(mk_row(0, 0, X_TOP, 1, 1));
      drain_pipe();

      // left turn with every offset at its top
      write_reg(lfps_pkg::CSR_TURN_MODE, lfps_pkg::CSR_DATA_BITS'(lfps_pkg::MODE_LEFT));
      write_reg(lfps_pkg::CSR_CAR_COLUMN, 24'h7FF);
      write_reg(lfps_pkg::CSR_LANE_SPAN, 24'h7FF);
      write_reg(lfps_pkg::CSR_CRUISE_SPEED, 24'hFF);
      csr_write <= 1'b0;
      send_row(mk_row(0, 0, 0, 0, 0));
      send_row(mk_row(0, 1, X_TOP, 0, 1));
      send_row(mk_row(0, 0, 0, 0, 0));
      send_row(mk_row(X_TOP, 1, 0, 0, 1));
      drain_pipe();

      phase = 0;
      while (rows_sent < ROW_TARGET) begin
         random_setup(phase);
         // first pass: neither side idles
         send_idle_pct = (phase == 0) ? 0 : 28;
         recv_idle_pct = (phase == 0) ? 0 : 28;
         frames = 8;
         // run past the last row index with the window wide open
         if (phase == 0) send_frame(260, 50);
         // hold the output while rows keep coming, until input backs up
         if (phase == 2) begin
            hold_ask = 1'b1;
            send_idle_pct = 0;
            frames = 15;
         end
         repeat (frames) begin
            send_frame(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14),
                       ($urandom_range(0, 2) == 0) ? 10 : 80);
         end
         drain_pipe();
         phase++;
      end

      if (steer_pred.faults == 0 && steer_pred.frame_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
